@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the instruction decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Same-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/mid_pkg.sv @@
// ----------------------------------------------------------------------------
// mid_pkg
// Types, kind codes and the operand format table of the MIPS32 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mid_pkg;

  localparam int unsigned KindW = 7;
  localparam int unsigned KindCount = 79;

  localparam logic [31:0] StartReset = 32'h0000_3000;
  localparam logic [31:0] EretWord = 32'h4200_0018;

  // Instruction kinds in alphabetical order; the last code marks an unknown word.
  typedef enum logic [KindW-1:0] {
    K_ADD = 7'd0, K_ADDI = 7'd1, K_ADDIU = 7'd2, K_ADDU = 7'd3, K_AND = 7'd4,
    K_ANDI = 7'd5, K_BEQ = 7'd6, K_BEQL = 7'd7, K_BGEZ = 7'd8, K_BGEZAL = 7'd9,
    K_BGEZALL = 7'd10, K_BGEZL = 7'd11, K_BGTZ = 7'd12, K_BGTZL = 7'd13,
    K_BLEZ = 7'd14, K_BLEZL = 7'd15, K_BLTZ = 7'd16, K_BLTZAL = 7'd17,
    K_BLTZALL = 7'd18, K_BLTZL = 7'd19, K_BNE = 7'd20, K_BNEL = 7'd21,
    K_BREAK = 7'd22, K_DIV = 7'd23, K_DIVU = 7'd24, K_ERET = 7'd25, K_J = 7'd26,
    K_JAL = 7'd27, K_JALR = 7'd28, K_JR = 7'd29, K_LB = 7'd30, K_LBU = 7'd31,
    K_LH = 7'd32, K_LHU = 7'd33, K_LUI = 7'd34, K_LW = 7'd35, K_MFC0 = 7'd36,
    K_MFHI = 7'd37, K_MFLO = 7'd38, K_MTC0 = 7'd39, K_MTHI = 7'd40,
    K_MTLO = 7'd41, K_MULT = 7'd42, K_MULTU = 7'd43, K_NOP = 7'd44,
    K_NOR = 7'd45, K_OR = 7'd46, K_ORI = 7'd47, K_SB = 7'd48, K_SH = 7'd49,
    K_SLL = 7'd50, K_SLLV = 7'd51, K_SLT = 7'd52, K_SLTI = 7'd53,
    K_SLTIU = 7'd54, K_SLTU = 7'd55, K_SRA = 7'd56, K_SRAV = 7'd57,
    K_SRL = 7'd58, K_SRLV = 7'd59, K_SUB = 7'd60, K_SUBU = 7'd61, K_SW = 7'd62,
    K_SYSCALL = 7'd63, K_TEQ = 7'd64, K_TEQI = 7'd65, K_TGE = 7'd66,
    K_TGEI = 7'd67, K_TGEIU = 7'd68, K_TGEU = 7'd69, K_TLT = 7'd70,
    K_TLTI = 7'd71, K_TLTIU = 7'd72, K_TLTU = 7'd73, K_TNE = 7'd74,
    K_TNEI = 7'd75, K_XOR = 7'd76, K_XORI = 7'd77, K_UNKNOWN = 7'd78
  } kind_e;

  // Operand format class for each kind; the unknown kind maps to zero.
  localparam logic [3:0] FmtClass [KindCount] = '{
    4'd0, 4'd3, 4'd3, 4'd0, 4'd0, 4'd3, 4'd5, 4'd5, 4'd10, 4'd10,
    4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd5, 4'd5, 4'd14, 4'd15, 4'd15, 4'd14, 4'd11, 4'd11, 4'd6, 4'd12,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd9, 4'd4, 4'd7, 4'd13, 4'd13, 4'd7,
    4'd12, 4'd12, 4'd15, 4'd15, 4'd14, 4'd0, 4'd0, 4'd3, 4'd4, 4'd4,
    4'd2, 4'd1, 4'd0, 4'd3, 4'd3, 4'd0, 4'd2, 4'd1, 4'd2, 4'd1,
    4'd0, 4'd0, 4'd4, 4'd14, 4'd15, 4'd8, 4'd15, 4'd8, 4'd8, 4'd15,
    4'd15, 4'd8, 4'd8, 4'd15, 4'd15, 4'd8, 4'd0, 4'd3, 4'd0
  };

  // Decode result handed from the decoder to the result stage.
  typedef struct packed {
    kind_e      kind;
    logic       unknown;
    logic [3:0] fmt_class;
  } dec_info_t;

endpackage

`default_nettype wire

@@ hdl/mid_decode.sv @@
// ----------------------------------------------------------------------------
// mid_decode
// Identifies the instruction kind of one word and looks up its format class.
// ----------------------------------------------------------------------------
`default_nettype none

module mid_decode (
  input  logic [31:0]        word_i,
  output mid_pkg::dec_info_t info_o
);
  import mid_pkg::*;

  // Primary opcodes.
  localparam logic [5:0] OpSpecial = 6'h00, OpRegimm = 6'h01, OpJ = 6'h02,
                         OpJal = 6'h03, OpBeq = 6'h04, OpBne = 6'h05,
                         OpBlez = 6'h06, OpBgtz = 6'h07, OpAddi = 6'h08,
                         OpAddiu = 6'h09, OpSlti = 6'h0a, OpSltiu = 6'h0b,
                         OpAndi = 6'h0c, OpOri = 6'h0d, OpXori = 6'h0e,
                         OpLui = 6'h0f, OpCop0 = 6'h10, OpBeql = 6'h14,
                         OpBnel = 6'h15, OpBlezl = 6'h16, OpBgtzl = 6'h17,
                         OpLb = 6'h20, OpLh = 6'h21, OpLw = 6'h23,
                         OpLbu = 6'h24, OpLhu = 6'h25, OpSb = 6'h28,
                         OpSh = 6'h29, OpSw = 6'h2b;

  // SPECIAL function codes.
  localparam logic [5:0] FnSll = 6'h00, FnSrl = 6'h02, FnSra = 6'h03,
                         FnSllv = 6'h04, FnSrlv = 6'h06, FnSrav = 6'h07,
                         FnJr = 6'h08, FnJalr = 6'h09, FnSyscall = 6'h0c,
                         FnBreak = 6'h0d, FnMfhi = 6'h10, FnMthi = 6'h11,
                         FnMflo = 6'h12, FnMtlo = 6'h13, FnMult = 6'h18,
                         FnMultu = 6'h19, FnDiv = 6'h1a, FnDivu = 6'h1b,
                         FnAdd = 6'h20, FnAddu = 6'h21, FnSub = 6'h22,
                         FnSubu = 6'h23, FnAnd = 6'h24, FnOr = 6'h25,
                         FnXor = 6'h26, FnNor = 6'h27, FnSlt = 6'h2a,
                         FnSltu = 6'h2b, FnTge = 6'h30, FnTgeu = 6'h31,
                         FnTlt = 6'h32, FnTltu = 6'h33, FnTeq = 6'h34,
                         FnTne = 6'h36;

  // REGIMM rt codes.
  localparam logic [4:0] RiBltz = 5'h00, RiBgez = 5'h01, RiBltzl = 5'h02,
                         RiBgezl = 5'h03, RiTgei = 5'h08, RiTgeiu = 5'h09,
                         RiTlti = 5'h0a, RiTltiu = 5'h0b, RiTeqi = 5'h0c,
                         RiTnei = 5'h0e, RiBltzal = 5'h10, RiBgezal = 5'h11,
                         RiBltzall = 5'h12, RiBgezall = 5'h13;

  // COP0 rs codes.
  localparam logic [4:0] CopMf = 5'h00, CopMt = 5'h04;

  logic [5:0] op;
  logic [5:0] funct;
  logic [4:0] rs;
  logic [4:0] rt;
  kind_e      prim_kind;
  kind_e      spec_kind;
  kind_e      rimm_kind;
  kind_e      kind;

  assign op    = word_i[31:26];
  assign rs    = word_i[25:21];
  assign rt    = word_i[20:16];
  assign funct = word_i[5:0];

  always_comb begin
    case (op)
      OpJ:     prim_kind = K_J;
      OpJal:   prim_kind = K_JAL;
      OpBeq:   prim_kind = K_BEQ;
      OpBne:   prim_kind = K_BNE;
      OpBlez:  prim_kind = K_BLEZ;
      OpBgtz:  prim_kind = K_BGTZ;
      OpAddi:  prim_kind = K_ADDI;
      OpAddiu: prim_kind = K_ADDIU;
      OpSlti:  prim_kind = K_SLTI;
      OpSltiu: prim_kind = K_SLTIU;
      OpAndi:  prim_kind = K_ANDI;
      OpOri:   prim_kind = K_ORI;
      OpXori:  prim_kind = K_XORI;
      OpLui:   prim_kind = K_LUI;
      OpBeql:  prim_kind = K_BEQL;
      OpBnel:  prim_kind = K_BNEL;
      OpBlezl: prim_kind = K_BLEZL;
      OpBgtzl: prim_kind = K_BGTZL;
      OpLb:    prim_kind = K_LB;
      OpLh:    prim_kind = K_LH;
      OpLw:    prim_kind = K_LW;
      OpLbu:   prim_kind = K_LBU;
      OpLhu:   prim_kind = K_LHU;
      OpSb:    prim_kind = K_SB;
      OpSh:    prim_kind = K_SH;
      OpSw:    prim_kind = K_SW;
      default: prim_kind = K_UNKNOWN;
    endcase
  end

  always_comb begin
    case (funct)
      FnSll:     spec_kind = K_SLL;
      FnSrl:     spec_kind = K_SRL;
      FnSra:     spec_kind = K_SRA;
      FnSllv:    spec_kind = K_SLLV;
      FnSrlv:    spec_kind = K_SRLV;
      FnSrav:    spec_kind = K_SRAV;
      FnJr:      spec_kind = K_JR;
      FnJalr:    spec_kind = K_JALR;
      FnSyscall: spec_kind = K_SYSCALL;
      FnBreak:   spec_kind = K_BREAK;
      FnMfhi:    spec_kind = K_MFHI;
      FnMthi:    spec_kind = K_MTHI;
      FnMflo:    spec_kind = K_MFLO;
      FnMtlo:    spec_kind = K_MTLO;
      FnMult:    spec_kind = K_MULT;
      FnMultu:   spec_kind = K_MULTU;
      FnDiv:     spec_kind = K_DIV;
      FnDivu:    spec_kind = K_DIVU;
      FnAdd:     spec_kind = K_ADD;
      FnAddu:    spec_kind = K_ADDU;
      FnSub:     spec_kind = K_SUB;
      FnSubu:    spec_kind = K_SUBU;
      FnAnd:     spec_kind = K_AND;
      FnOr:      spec_kind = K_OR;
      FnXor:     spec_kind = K_XOR;
      FnNor:     spec_kind = K_NOR;
      FnSlt:     spec_kind = K_SLT;
      FnSltu:    spec_kind = K_SLTU;
      FnTge:     spec_kind = K_TGE;
      FnTgeu:    spec_kind = K_TGEU;
      FnTlt:     spec_kind = K_TLT;
      FnTltu:    spec_kind = K_TLTU;
      FnTeq:     spec_kind = K_TEQ;
      FnTne:     spec_kind = K_TNE;
      default:   spec_kind = K_UNKNOWN;
    endcase
  end

  always_comb begin
    case (rt)
      RiBltz:    rimm_kind = K_BLTZ;
      RiBgez:    rimm_kind = K_BGEZ;
      RiBltzl:   rimm_kind = K_BLTZL;
      RiBgezl:   rimm_kind = K_BGEZL;
      RiTgei:    rimm_kind = K_TGEI;
      RiTgeiu:   rimm_kind = K_TGEIU;
      RiTlti:    rimm_kind = K_TLTI;
      RiTltiu:   rimm_kind = K_TLTIU;
      RiTeqi:    rimm_kind = K_TEQI;
      RiTnei:    rimm_kind = K_TNEI;
      RiBltzal:  rimm_kind = K_BLTZAL;
      RiBgezal:  rimm_kind = K_BGEZAL;
      RiBltzall: rimm_kind = K_BLTZALL;
      RiBgezall: rimm_kind = K_BGEZALL;
      default:   rimm_kind = K_UNKNOWN;
    endcase
  end

  // The all-zero word is a NOP rather than SLL, and ERET is matched by its whole word.
  always_comb begin
    case (op)
      OpSpecial: begin
        if (word_i == '0) begin
          kind = K_NOP;
        end else begin
          kind = spec_kind;
        end
      end
      OpRegimm: kind = rimm_kind;
      OpCop0: begin
        if (word_i == EretWord) begin
          kind = K_ERET;
        end else if (rs == CopMf) begin
          kind = K_MFC0;
        end else if (rs == CopMt) begin
          kind = K_MTC0;
        end else begin
          kind = K_UNKNOWN;
        end
      end
      default: kind = prim_kind;
    endcase
  end

  assign info_o.kind      = kind;
  assign info_o.unknown   = (kind == K_UNKNOWN);
  assign info_o.fmt_class = FmtClass[kind];

endmodule

`default_nettype wire

@@ hdl/mid_target.sv @@
// ----------------------------------------------------------------------------
// mid_target
// Computes the jump-region or PC-relative branch target of one word.
// ----------------------------------------------------------------------------
`default_nettype none

module mid_target (
  input  logic [31:0]    word_i,
  input  logic [31:0]    pc_i,
  input  mid_pkg::kind_e kind_i,
  output logic [31:0]    target_o
);
  import mid_pkg::*;

  logic [31:0] next_pc;
  logic [31:0] branch_off;

  assign next_pc    = pc_i + 32'd4;
  assign branch_off = {{14{word_i[15]}}, word_i[15:0], 2'b00};

  always_comb begin
    if (kind_i == K_J || kind_i == K_JAL) begin
      target_o = {next_pc[31:28], word_i[25:0], 2'b00};
    end else begin
      target_o = next_pc + branch_off;
    end
  end

endmodule

`default_nettype wire

@@ hdl/mips_instruction_decoder.sv @@
// ----------------------------------------------------------------------------
// mips_instruction_decoder
// MIPS32 instruction decoder: kind, format class, fields and target address.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                      Payload
//   input     in         in_valid_i / in_ready_o        instr_word_i
//   result    out        out_valid_o / out_ready_i      kind_o .. instr_address_o
//   config    in         psel/penable/pwrite, pready=1  paddr, pwdata, prdata
//
// One beat is accepted per cycle when the result side keeps up; the sustained
// rate is one instruction per clock while out_ready_i stays high.
// A result passes from the input register through decode and the 32-bit target
// adder into the result register.
// A stalled result holds the result register; the input register still takes one
// more beat if it is empty, and after that in_ready_o stays low until out_ready_i
// returns. in_ready_o follows out_ready_i in the same cycle, with no extra bubble.
// Reset clears both valid flags and loads the start address and running PC with 0x3000.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mips_instruction_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instr_word_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  kind_o,
  output logic        unknown_o,
  output logic [3:0]  format_class_o,
  output logic [4:0]  rs_field_o,
  output logic [4:0]  rt_field_o,
  output logic [4:0]  rd_field_o,
  output logic [4:0]  shift_amount_o,
  output logic [15:0] imm_field_o,
  output logic [31:0] target_address_o,
  output logic [31:0] instr_address_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mid_pkg::*;

  // Register index of the start address in the configuration space.
  localparam logic RegStartAddr = 1'b0;

  // Configuration: the start address register and the running PC.
  logic        cfg_we;
  logic [31:0] start_q;
  logic [31:0] pc_q;

  // Input register: the raw word and the address it was fetched at.
  logic        s1_valid_q;
  logic [31:0] s1_word_q;
  logic [31:0] s1_pc_q;

  // Result register.
  logic        s2_valid_q;
  dec_info_t   s2_info_q;
  logic [31:0] s2_word_q;
  logic [31:0] s2_target_q;
  logic [31:0] s2_pc_q;

  logic        in_acc;
  logic        s2_load;
  logic        s1_adv;
  dec_info_t   dec_info;
  logic [31:0] target;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == RegStartAddr);
  assign prdata = (paddr[2] == RegStartAddr) ? start_q : '0;

  // The result register takes a new beat when it is empty or being drained; the input
  // register moves into it when it holds one at such a time, and refills in the same cycle.
  assign s2_load    = !s2_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && s2_load;
  assign in_ready_o = !s1_valid_q || s2_load;
  assign in_acc     = in_valid_i && in_ready_o;

  // A write to the start address also restarts the running PC there. The user must
  // write only while the pipeline is idle; the block itself does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartReset;
      pc_q    <= StartReset;
    end else if (cfg_we) begin
      start_q <= pwdata;
      pc_q    <= pwdata;
    end else if (in_acc) begin
      pc_q    <= pc_q + 32'd4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_word_q <= instr_word_i;
      s1_pc_q   <= pc_q;
    end
  end

  mid_decode u_decode (
    .word_i (s1_word_q),
    .info_o (dec_info)
  );

  mid_target u_target (
    .word_i   (s1_word_q),
    .pc_i     (s1_pc_q),
    .kind_i   (dec_info.kind),
    .target_o (target)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_load) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_info_q   <= dec_info;
      s2_word_q   <= s1_word_q;
      s2_target_q <= target;
      s2_pc_q     <= s1_pc_q;
    end
  end

  // The register, shift and immediate fields are plain slices of the stored word.
  assign out_valid_o      = s2_valid_q;
  assign kind_o           = s2_info_q.kind;
  assign unknown_o        = s2_info_q.unknown;
  assign format_class_o   = s2_info_q.fmt_class;
  assign rs_field_o       = s2_word_q[25:21];
  assign rt_field_o       = s2_word_q[20:16];
  assign rd_field_o       = s2_word_q[15:11];
  assign shift_amount_o   = s2_word_q[10:6];
  assign imm_field_o      = s2_word_q[15:0];
  assign target_address_o = s2_target_q;
  assign instr_address_o  = s2_pc_q;

  // Every accepted beat without a concurrent write advances the PC by one word.
  `ASSERT_NEXT(a_pc_step, clk_i, rst_ni, in_acc && !cfg_we, pc_q == $past(pc_q) + 32'd4)
  // A beat held in the input register while the result side stalls is not lost.
  `ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s2_load,
               s1_valid_q && $stable(s1_word_q) && $stable(s1_pc_q))
  // The unknown flag and the kind code agree on every result.
  `ASSERT_IMPL(a_unknown_kind, clk_i, rst_ni, out_valid_o,
               unknown_o == (kind_o == K_UNKNOWN))
  // An unknown word carries no format class.
  `ASSERT_IMPL(a_unknown_class, clk_i, rst_ni, out_valid_o && unknown_o,
               format_class_o == 4'd0)

endmodule

`default_nettype wire
